### hdl/sea_pkg.sv
// Shared types and constants for the sector extent allocator.
// No dependencies; every other file except sea_ram imports this package.
package sea_pkg;

  localparam int unsigned MAX_EXTENTS_DEFAULT = 64;

  localparam int unsigned ACT_W   = 2;
  localparam int unsigned SEC_W   = 11;
  localparam int unsigned LEN_W   = 19;
  localparam int unsigned SIZE_W  = 12;
  localparam int unsigned EXT_W   = 12;
  localparam int unsigned FDS_W   = 3;
  localparam int unsigned CFG_W   = 11;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_DATA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL      = 2'd1;

  localparam logic [FDS_W-1:0] FDS_RESET = 3'd2;
  localparam logic [SEC_W-1:0] TOT_RESET = 11'd800;

  typedef enum logic [ACT_W-1:0] {
    ACT_INIT = 2'd0,
    ACT_MARK = 2'd1,
    ACT_FIND = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    WR_NONE      = 3'd0,
    WR_INIT      = 3'd1,
    WR_HEAD      = 3'd2,
    WR_TAIL      = 3'd3,
    WR_SPLIT_NEW = 3'd4
  } wr_sel_e;

  typedef struct packed {
    logic    capture;
    logic    idx_clr;
    logic    idx_inc;
    wr_sel_e wr_sel;
    logic    cnt_init;
    logic    cnt_inc;
    logic    set_corrupt;
    logic    set_found;
    logic    save_end;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    action_e act;
    logic    size_zero;
    logic    fits;
    logic    contains;
    logic    head;
    logic    tail;
    logic    full;
    logic    last;
    logic    out_busy;
  } sts_t;

endpackage

### hdl/sea_req_if.sv
// Request channel: valid/ready handshake with action and range fields.
// Depends on sea_pkg for field widths.
interface sea_req_if;
  import sea_pkg::*;

  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [SEC_W-1:0] start_sector;
  logic [LEN_W-1:0] length_bytes;

  modport source (output valid, action, start_sector, length_bytes, input ready);
  modport sink   (input valid, action, start_sector, length_bytes, output ready);
endinterface

### hdl/sea_rsp_if.sv
// Response channel: valid/ready handshake with find result and corrupt flag.
// Depends on sea_pkg for field widths.
interface sea_rsp_if;
  import sea_pkg::*;

  logic             valid;
  logic             ready;
  logic [SEC_W-1:0] found_sector;
  logic             found;
  logic             corrupt;

  modport source (output valid, found_sector, found, corrupt, input ready);
  modport sink   (input valid, found_sector, found, corrupt, output ready);
endinterface

### hdl/sector_extent_allocator.sv
// First-fit free extent table: init, mark range used, find free space.
// One request at a time. A request passes dispatch, then a scan over the entries (for
// mark and find with nonzero length; up to the extent count, at most MAX_EXTENTS),
// then a split state when a mark splits an extent, then the response state. The next
// request is taken only after the result is loaded, later while a result is held off.
// Reset: count 1, corrupt clear, config 2 / 800; RAM contents undefined until init.
module sector_extent_allocator #(
  parameter int unsigned MAX_EXTENTS = sea_pkg::MAX_EXTENTS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sea_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sea_pkg::CFG_W-1:0]     cfg_wdata_i,
  sea_req_if.sink                       req_i,
  sea_rsp_if.source                     rsp_o
);
  import sea_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sea_dp #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_action_i  (req_i.action),
    .req_start_i   (req_i.start_sector),
    .req_len_i     (req_i.length_bytes),
    .rsp_ready_i   (rsp_o.ready),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_sector_o  (rsp_o.found_sector),
    .rsp_found_o   (rsp_o.found),
    .rsp_corrupt_o (rsp_o.corrupt),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule

### hdl/sea_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sea_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sea_ctrl.sv
// Sequencer for the extent allocator: dispatch, table scan, split, response.
// Depends on sea_pkg for the command and status structs.
module sea_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  sea_pkg::sts_t sts_i,
  output sea_pkg::cmd_t cmd_o
);
  import sea_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DISP  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_SPLIT = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.wr_sel = WR_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = S_RESP;
        case (sts_i.act)
          ACT_INIT: begin
            cmd_o.wr_sel   = WR_INIT;
            cmd_o.cnt_init = 1'b1;
          end
          ACT_MARK, ACT_FIND: begin
            if (!sts_i.size_zero) begin
              cmd_o.idx_clr = 1'b1;
              state_d = S_SCAN;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (sts_i.act == ACT_FIND) begin
          if (sts_i.fits) begin
            cmd_o.set_found = 1'b1;
            state_d = S_RESP;
          end else if (sts_i.last) begin
            state_d = S_RESP;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end else begin
          if (sts_i.contains) begin
            state_d = S_RESP;
            if (sts_i.head) begin
              cmd_o.wr_sel = WR_HEAD;
            end else if (sts_i.tail) begin
              cmd_o.wr_sel = WR_TAIL;
            end else if (sts_i.full) begin
              cmd_o.set_corrupt = 1'b1;
            end else begin
              // old entry keeps the head now, tail part is appended next cycle
              cmd_o.wr_sel   = WR_TAIL;
              cmd_o.save_end = 1'b1;
              state_d = S_SPLIT;
            end
          end else if (sts_i.last) begin
            cmd_o.set_corrupt = 1'b1;
            state_d = S_RESP;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end
      end
      S_SPLIT: begin
        cmd_o.wr_sel  = WR_SPLIT_NEW;
        cmd_o.cnt_inc = 1'b1;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/sea_dp.sv
// Datapath: config registers, request latch, extent RAM, compare logic,
// extent count, corrupt flag and response register. Depends on sea_pkg, sea_ram.
module sea_dp #(
  parameter int unsigned MAX_EXTENTS = sea_pkg::MAX_EXTENTS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sea_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sea_pkg::CFG_W-1:0]      cfg_wdata_i,
  input  logic [sea_pkg::ACT_W-1:0]      req_action_i,
  input  logic [sea_pkg::SEC_W-1:0]      req_start_i,
  input  logic [sea_pkg::LEN_W-1:0]      req_len_i,
  input  logic                           rsp_ready_i,
  output logic                           rsp_valid_o,
  output logic [sea_pkg::SEC_W-1:0]      rsp_sector_o,
  output logic                           rsp_found_o,
  output logic                           rsp_corrupt_o,
  input  sea_pkg::cmd_t                  cmd_i,
  output sea_pkg::sts_t                  sts_o
);
  import sea_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_EXTENTS);
  localparam int unsigned CNT_W = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned ENT_W = 2 * EXT_W;
  localparam int unsigned AR_W  = EXT_W + 2;

  // configuration
  logic [FDS_W-1:0] fds_q;
  logic [SEC_W-1:0] tot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fds_q <= FDS_RESET;
      tot_q <= TOT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIRST_DATA: fds_q <= cfg_wdata_i[FDS_W-1:0];
        CFG_TOTAL:      tot_q <= cfg_wdata_i[SEC_W-1:0];
        default: ;
      endcase
    end
  end

  // request latch
  action_e           act_q;
  logic [SEC_W-1:0]  sec_q;
  logic [SIZE_W-1:0] size_q;
  logic [LEN_W:0]    len_rnd;

  assign len_rnd = {1'b0, req_len_i} + (LEN_W + 1)'(255);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q  <= action_e'(req_action_i);
      sec_q  <= req_start_i;
      size_q <= len_rnd[LEN_W:8];
    end
  end

  // scan index and extent count
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + IDX_W'(1);
    end
    cnt_d = cnt_q;
    if (cmd_i.cnt_init) begin
      cnt_d = CNT_W'(1);
    end else if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= CNT_W'(1);
    end else begin
      idx_q <= idx_d;
      cnt_q <= cnt_d;
    end
  end

  // extent RAM; entry word is {start, end}, read data belongs to idx_q
  logic [ENT_W-1:0] rdata;
  logic [ENT_W-1:0] wdata;
  logic [IDX_W-1:0] waddr;
  logic             we;

  sea_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_EXTENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_d),
    .rdata_o (rdata)
  );

  // signed compare arithmetic, two bits of headroom over the stored width
  logic signed [AR_W-1:0] ent_s, ent_e, sec_a, size_a, last_a;
  logic [EXT_W-1:0]       split_end_q;
  logic [EXT_W-1:0]       tot_m1;

  assign ent_s  = AR_W'(signed'(rdata[ENT_W-1:EXT_W]));
  assign ent_e  = AR_W'(signed'(rdata[EXT_W-1:0]));
  assign sec_a  = signed'(AR_W'(sec_q));
  assign size_a = signed'(AR_W'(size_q));
  assign last_a = sec_a + size_a - AR_W'(1);
  assign tot_m1 = EXT_W'(tot_q) - EXT_W'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.save_end) begin
      split_end_q <= rdata[EXT_W-1:0];
    end
  end

  always_comb begin
    we    = 1'b1;
    waddr = idx_q;
    wdata = rdata;
    case (cmd_i.wr_sel)
      WR_INIT: begin
        waddr = '0;
        wdata = {EXT_W'(fds_q), tot_m1};
      end
      WR_HEAD: begin
        wdata = {EXT_W'(ent_s + size_a), rdata[EXT_W-1:0]};
      end
      WR_TAIL: begin
        wdata = {rdata[ENT_W-1:EXT_W], EXT_W'(sec_a - AR_W'(1))};
      end
      WR_SPLIT_NEW: begin
        waddr = cnt_q[IDX_W-1:0];
        wdata = {EXT_W'(last_a + AR_W'(1)), split_end_q};
      end
      default: we = 1'b0;
    endcase
  end

  // status
  assign sts_o.act       = act_q;
  assign sts_o.size_zero = (size_q == '0);
  assign sts_o.fits      = (ent_e >= ent_s) && ((ent_e - ent_s) >= (size_a - AR_W'(1)));
  assign sts_o.contains  = (ent_s <= sec_a) && (ent_e >= last_a);
  assign sts_o.head      = (ent_s == sec_a);
  assign sts_o.tail      = (last_a == ent_e);
  assign sts_o.full      = (cnt_q >= CNT_W'(MAX_EXTENTS));
  assign sts_o.last      = ((CNT_W'(idx_q) + CNT_W'(1)) >= cnt_q);
  assign sts_o.out_busy  = rsp_valid_o && !rsp_ready_i;

  // result and sticky flag
  logic             corrupt_q;
  logic             found_q;
  logic [SEC_W-1:0] found_sec_q;
  logic             out_valid_q;
  logic [SEC_W-1:0] out_sec_q;
  logic             out_found_q;
  logic             out_corrupt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corrupt_q   <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.set_corrupt) begin
        corrupt_q <= 1'b1;
      end
      if (cmd_i.capture) begin
        found_q <= 1'b0;
      end else if (cmd_i.set_found) begin
        found_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.set_found) begin
      found_sec_q <= rdata[ENT_W-2:EXT_W];
    end
    if (cmd_i.load_out) begin
      out_sec_q     <= found_q ? found_sec_q : '0;
      out_found_q   <= found_q;
      out_corrupt_q <= corrupt_q;
    end
  end

  assign rsp_valid_o   = out_valid_q;
  assign rsp_sector_o  = out_sec_q;
  assign rsp_found_o   = out_found_q;
  assign rsp_corrupt_o = out_corrupt_q;

endmodule

### bench/sector_extent_allocator_checker.sv
`timescale 1ns / 1ps
// Checker for sector_extent_allocator: follows the configuration port and both
// channels, keeps its own free extent table and compares each response with the
// oldest predicted one. Depends on sea_pkg, sea_req_if and sea_rsp_if.
module sector_extent_allocator_checker #(
  parameter int unsigned MAX_EXTENTS = sea_pkg::MAX_EXTENTS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sea_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [sea_pkg::CFG_W-1:0]     cfg_wdata_i,
  sea_req_if                            req,
  sea_rsp_if                            rsp,
  output int unsigned                   fail_count_o,
  output int unsigned                   outstanding_o,
  output int unsigned                   checked_o,
  output int unsigned                   hits_o,
  output int unsigned                   splits_o,
  output int unsigned                   overflows_o
);
  import sea_pkg::*;

  localparam int unsigned PRINT_CAP = 50;

  typedef struct packed {
    logic [SEC_W-1:0] found_sector;
    logic             found;
    logic             corrupt;
  } answer_t;

  answer_t          answer_q[$];
  logic [EXT_W-1:0] free_lo [MAX_EXTENTS];
  logic [EXT_W-1:0] free_hi [MAX_EXTENTS];
  int unsigned      n_free = 1;
  logic             bad_flag = 1'b0;
  logic [FDS_W-1:0] first_sec = FDS_RESET;
  logic [SEC_W-1:0] disc_size = TOT_RESET;
  int unsigned      fail_count = 0;
  int unsigned      checked = 0;
  int unsigned      hits = 0;
  int unsigned      splits = 0;
  int unsigned      overflows = 0;

  // table entries are 12-bit two's complement
  function automatic int widen12(logic [EXT_W-1:0] v);
    return $signed(v);
  endfunction

  function automatic logic [EXT_W-1:0] wrap12(int x);
    return x[EXT_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP)
      $display("[%0t] CHECK: %s", $time, msg);
    fail_count++;
  endtask

  // Updates the table for one request and returns the response it should give.
  task automatic apply_request(input logic [ACT_W-1:0] act, input logic [SEC_W-1:0] sec_in,
                               input logic [LEN_W-1:0] len_in, output answer_t ans);
    int          sec, size, last_sec, s, e, where;
    int unsigned i;
    bit          hit, fit;
    sec      = sec_in;
    size     = (int'(len_in) + 255) / 256;
    last_sec = sec + size - 1;
    hit      = 1'b0;
    fit      = 1'b0;
    where    = 0;
    case (act)
      ACT_INIT: begin
        n_free     = 1;
        free_lo[0] = wrap12(int'(first_sec));
        free_hi[0] = wrap12(int'(disc_size) - 1);
      end
      ACT_MARK: begin
        if (size != 0) begin
          for (i = 0; i < n_free && !hit; i++) begin
            s = widen12(free_lo[i]);
            e = widen12(free_hi[i]);
            if (s <= sec && e >= last_sec) begin
              hit = 1'b1;
              if (s == sec) begin
                free_lo[i] = wrap12(s + size);
              end else if (last_sec == e) begin
                free_hi[i] = wrap12(sec - 1);
              end else if (n_free >= MAX_EXTENTS) begin
                bad_flag = 1'b1;
                overflows++;
              end else begin
                // tail part goes to a new entry, starting one past the range
                free_lo[n_free] = wrap12(last_sec + 1);
                free_hi[n_free] = wrap12(e);
                n_free++;
                free_hi[i] = wrap12(sec - 1);
                splits++;
              end
            end
          end
          if (!hit) bad_flag = 1'b1;
        end
      end
      ACT_FIND: begin
        if (size != 0) begin
          for (i = 0; i < n_free && !fit; i++) begin
            s = widen12(free_lo[i]);
            e = widen12(free_hi[i]);
            if (e >= s && e - s >= size - 1) begin
              fit   = 1'b1;
              where = s;
            end
          end
          if (fit) hits++;
        end
      end
      default: ;
    endcase
    ans.found_sector = fit ? where[SEC_W-1:0] : '0;
    ans.found        = fit;
    ans.corrupt      = bad_flag;
  endtask

  always @(posedge clk_i) begin
    answer_t want;
    if (!rst_ni) begin
      answer_q.delete();
      n_free    = 1;
      bad_flag  = 1'b0;
      first_sec = FDS_RESET;
      disc_size = TOT_RESET;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          report_mismatch("response transfer with no request waiting");
        end else begin
          want = answer_q.pop_front();
          if (rsp.found_sector !== want.found_sector)
            report_mismatch($sformatf("result %0d: found_sector %0d, expected %0d",
                                      checked, rsp.found_sector, want.found_sector));
          if (rsp.found !== want.found)
            report_mismatch($sformatf("result %0d: found %0b, expected %0b",
                                      checked, rsp.found, want.found));
          if (rsp.corrupt !== want.corrupt)
            report_mismatch($sformatf("result %0d: corrupt %0b, expected %0b",
                                      checked, rsp.corrupt, want.corrupt));
          checked++;
        end
      end
      if (req.valid && req.ready) begin
        apply_request(req.action, req.start_sector, req.length_bytes, want);
        answer_q.push_back(want);
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_FIRST_DATA: first_sec = cfg_wdata_i[FDS_W-1:0];
          CFG_TOTAL:      disc_size = cfg_wdata_i[SEC_W-1:0];
          default: ;
        endcase
      end
    end
    fail_count_o  <= fail_count;
    outstanding_o <= answer_q.size();
    checked_o     <= checked;
    hits_o        <= hits;
    splits_o      <= splits;
    overflows_o   <= overflows;
  end

endmodule

### bench/sector_extent_allocator_tb.sv
`timescale 1ns / 1ps
// Testbench top for sector_extent_allocator: clock, reset, configuration and
// request stimulus, response back-pressure, watchdog and verdict.
// Depends on sea_pkg, the channel interfaces and the checker module.
module sector_extent_allocator_tb;
  import sea_pkg::*;

  localparam int unsigned ITEM_TARGET  = 450;
  localparam int unsigned IDLE_PCT     = 25;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned FRAG_ITEMS   = 90;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [ACT_W-1:0]     ACT_SPARE    = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  sea_req_if req ();
  sea_rsp_if rsp ();

  int unsigned fail_count, outstanding, checked, hits, splits, overflows;

  bit          calm = 1'b0;
  bit          hold_go = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned n_sent = 0;

  int unsigned fds_cur = FDS_RESET;
  int unsigned tot_cur = TOT_RESET;
  int unsigned head_ptr, comb_ptr, comb_step;

  sector_extent_allocator dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .req_i      (req),
    .rsp_o      (rsp)
  );

  sector_extent_allocator_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .req          (req),
    .rsp          (rsp),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding),
    .checked_o    (checked),
    .hits_o       (hits),
    .splits_o     (splits),
    .overflows_o  (overflows)
  );

  always #4 clk_i = ~clk_i;

  // Response side: random stalls, plus one long hold-off to back up the block.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      rsp.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      rsp.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", stall_cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_req(input logic [ACT_W-1:0] act, input logic [SEC_W-1:0] sec,
                          input logic [LEN_W-1:0] len);
    if (!calm) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        req.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req.valid        <= 1'b1;
    req.action       <= act;
    req.start_sector <= sec;
    req.length_bytes <= len;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop offering and wait until every response is back.
  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_geometry(input int unsigned fds, input int unsigned tot);
    logic [CFG_W-1:0] word;
    settle();
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, CFG_W'($urandom));
    // upper bits of the first-data write are don't care
    word            = CFG_W'($urandom);
    word[FDS_W-1:0] = fds[FDS_W-1:0];
    write_reg(CFG_FIRST_DATA, word);
    write_reg(CFG_TOTAL, tot[CFG_W-1:0]);
    fds_cur = fds;
    tot_cur = tot;
  endtask

  task automatic start_table();
    send_req(ACT_INIT, SEC_W'($urandom), LEN_W'($urandom));
    head_ptr = fds_cur;
    comb_ptr = (tot_cur > fds_cur) ? fds_cur + (tot_cur - fds_cur) / 2 : fds_cur;
  endtask

  // Mostly a few sectors, now and then large, rarely the whole field.
  function automatic logic [LEN_W-1:0] random_len();
    case ($urandom_range(0, 9))
      0:       return LEN_W'($urandom);
      1, 2:    return LEN_W'($urandom_range(1, 32768));
      default: return LEN_W'($urandom_range(1, 2048));
    endcase
  endfunction

  task automatic mixed_item();
    int unsigned      pick;
    logic [LEN_W-1:0] len;
    pick = $urandom_range(0, 99);
    len  = random_len();
    if (pick < 30) begin
      // allocate from the front of free space
      send_req(ACT_MARK, SEC_W'(head_ptr), len);
      head_ptr += (int'(len) + 255) / 256;
    end else if (pick < 45) begin
      // single sectors out of the middle force splits
      send_req(ACT_MARK, SEC_W'(comb_ptr), LEN_W'($urandom_range(1, 256)));
      comb_ptr += comb_step;
    end else if (pick < 72) begin
      send_req(ACT_FIND, SEC_W'($urandom), len);
    end else if (pick < 82) begin
      send_req(ACT_MARK, SEC_W'($urandom), LEN_W'($urandom));
    end else if (pick < 88) begin
      send_req($urandom_range(0, 1) ? ACT_MARK : ACT_FIND, SEC_W'($urandom), '0);
    end else if (pick < 93) begin
      send_req(ACT_SPARE, SEC_W'($urandom), LEN_W'($urandom));
    end else if (pick < 96) begin
      start_table();
    end else begin
      send_req(ACT_FIND, SEC_W'($urandom), LEN_W'($urandom));
    end
  endtask

  initial begin
    int unsigned phase, k, n_items, fds, tot;
    bit          fragment;
    rst_ni            = 1'b0;
    cfg_we           <= 1'b0;
    cfg_idx          <= '0;
    cfg_wdata        <= '0;
    req.valid        <= 1'b0;
    req.action       <= '0;
    req.start_sector <= '0;
    req.length_bytes <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: one extent 2..799
    send_req(ACT_INIT, '0, '0);
    send_req(ACT_FIND, '0, '0);                   // zero length never fits
    send_req(ACT_FIND, '0, 19'd1);
    send_req(ACT_FIND, 11'h7ff, 19'h7ffff);
    send_req(ACT_FIND, '0, 19'd204288);           // exactly 798 sectors
    send_req(ACT_FIND, '0, 19'd204289);
    send_req(ACT_MARK, 11'd2, '0);                // zero length marks nothing
    send_req(ACT_MARK, 11'd2, 19'd256);           // head -> 3..799
    send_req(ACT_MARK, 11'd799, 19'd1);           // tail -> 3..798
    send_req(ACT_MARK, 11'd100, 19'd512);         // split -> 3..99, 102..798
    send_req(ACT_FIND, '0, 19'd24832);            // 97 sectors fit the first
    send_req(ACT_FIND, '0, 19'd24833);            // 98 go to the tail extent
    send_req(ACT_SPARE, 11'h7ff, 19'h7ffff);

    // unused indexes are ignored; first-data write carries junk upper bits
    settle();
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '0);
    write_reg(CFG_FIRST_DATA, 11'h7fc);
    write_reg(CFG_TOTAL, 11'h7ff);
    fds_cur = 4;
    tot_cur = 2047;
    send_req(ACT_INIT, 11'h7ff, 19'h7ffff);       // 4..2046
    send_req(ACT_FIND, '0, 19'd523008);
    send_req(ACT_FIND, '0, 19'd523009);
    send_req(ACT_MARK, 11'd4, 19'd523008);        // takes the whole extent
    send_req(ACT_FIND, '0, 19'd1);

    // disc smaller than the first data sector: empty table
    set_geometry(2, 1);
    send_req(ACT_INIT, '0, '0);
    send_req(ACT_FIND, '0, 19'd1);
    send_req(ACT_MARK, 11'd2, 19'd1);
    send_req(ACT_INIT, '0, '0);                   // flag stays set

    phase = 0;
    while (n_sent < ITEM_TARGET) begin
      fragment = (phase == 1);
      fds      = $urandom_range(2, 4);
      if (fragment) begin
        tot = 2047;
      end else begin
        case ($urandom_range(0, 5))
          0:       tot = 1;
          1:       tot = $urandom_range(2, 6);
          2:       tot = 2047;
          3:       tot = 800;
          default: tot = $urandom_range(8, 2047);
        endcase
      end
      set_geometry(fds, tot);
      calm      = (phase == 2);
      comb_step = $urandom_range(2, 4);
      start_table();
      if (fragment) begin
        // enough splits to fill the table; the receiver holds off once, from the eleventh item
        for (k = 0; k < FRAG_ITEMS; k++) begin
          if (k == 10) hold_go = 1'b1;
          if ($urandom_range(0, 9) != 0) begin
            send_req(ACT_MARK, SEC_W'(comb_ptr), LEN_W'($urandom_range(1, 256)));
            comb_ptr += comb_step;
          end else begin
            send_req(ACT_FIND, SEC_W'($urandom), random_len());
          end
        end
      end else begin
        n_items = $urandom_range(30, 70);
        for (k = 0; k < n_items; k++) mixed_item();
      end
      phase++;
    end

    settle();
    calm = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Ran %0d requests over %0d table phases; %0d responses compared.",
             n_sent, phase + 3, checked);
    $display("Finds with space: %0d, extent splits: %0d, splits refused on full table: %0d.",
             hits, splits, overflows);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
